/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/y2r_pkg.sv */
// Types and constants of the YUYV to RGBA converter.
package y2r_pkg;

  typedef logic [7:0]         chan_t;
  typedef logic signed [17:0] prod_t;
  typedef logic signed [19:0] sum_t;

  // BT.601 video-range coefficients, scaled by 256
  localparam prod_t K_LUMA  = 18'sd298;
  localparam prod_t K_CR_R  = 18'sd409;
  localparam prod_t K_CB_G  = 18'sd100;
  localparam prod_t K_CR_G  = 18'sd208;
  localparam prod_t K_CB_B  = 18'sd516;
  localparam sum_t  K_ROUND = 20'sd128;

  localparam logic signed [9:0] LUMA_BASE   = 10'sd16;
  localparam logic signed [8:0] CHROMA_BASE = 9'sd128;
  localparam chan_t             CHAN_MAX    = 8'hFF;

  // Stage 1 result: all constant products
  typedef struct packed {
    prod_t luma_even;
    prod_t luma_odd;
    prod_t cr_r;
    prod_t cb_g;
    prod_t cr_g;
    prod_t cb_b;
    logic  frame_end;
  } y2r_prod_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } y2r_rgb_sum_t;

  // Stage 2 result: rounded channel sums, 8 fraction bits
  typedef struct packed {
    y2r_rgb_sum_t even;
    y2r_rgb_sum_t odd;
    logic         frame_end;
  } y2r_sum_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } y2r_pix_t;

  // Stage 3 result: saturated pixel pair
  typedef struct packed {
    y2r_pix_t even;
    y2r_pix_t odd;
    logic     frame_end;
  } y2r_pair_t;

endpackage

/* rtl/core/y2r_mul.sv */
// Stage 1: offset removal and constant multiplies.
module y2r_mul
  import y2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  output logic      in_rdy,
  input  chan_t     luma_even,
  input  chan_t     chroma_blue,
  input  chan_t     luma_odd,
  input  chan_t     chroma_red,
  input  logic      frame_end,
  output logic      out_vld,
  input  logic      out_rdy,
  output y2r_prod_t out_data
);

  logic              vld_r;
  y2r_prod_t         data_r;
  y2r_prod_t         data_nxt;
  logic signed [9:0] c_even;
  logic signed [9:0] c_odd;
  logic signed [8:0] d_cb;
  logic signed [8:0] e_cr;

  assign in_rdy = !vld_r || out_rdy;

  always_comb begin
    c_even = $signed({2'b00, luma_even}) - LUMA_BASE;
    c_odd  = $signed({2'b00, luma_odd}) - LUMA_BASE;
    d_cb   = $signed({1'b0, chroma_blue}) - CHROMA_BASE;
    e_cr   = $signed({1'b0, chroma_red}) - CHROMA_BASE;

    data_nxt.luma_even = prod_t'(c_even) * K_LUMA;
    data_nxt.luma_odd  = prod_t'(c_odd) * K_LUMA;
    data_nxt.cr_r      = prod_t'(e_cr) * K_CR_R;
    data_nxt.cb_g      = prod_t'(d_cb) * K_CB_G;
    data_nxt.cr_g      = prod_t'(e_cr) * K_CR_G;
    data_nxt.cb_b      = prod_t'(d_cb) * K_CB_B;
    data_nxt.frame_end = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

/* rtl/core/y2r_sum.sv */
// Stage 2: channel sums with rounding term.
module y2r_sum
  import y2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  output logic      in_rdy,
  input  y2r_prod_t in_data,
  output logic      out_vld,
  input  logic      out_rdy,
  output y2r_sum_t  out_data
);

  logic     vld_r;
  y2r_sum_t data_r;
  y2r_sum_t data_nxt;
  sum_t     base_even;
  sum_t     base_odd;
  sum_t     r_add;
  sum_t     g_sub;
  sum_t     b_add;

  assign in_rdy = !vld_r || out_rdy;

  always_comb begin
    base_even = sum_t'(in_data.luma_even) + K_ROUND;
    base_odd  = sum_t'(in_data.luma_odd) + K_ROUND;
    r_add     = sum_t'(in_data.cr_r);
    g_sub     = sum_t'(in_data.cb_g) + sum_t'(in_data.cr_g);
    b_add     = sum_t'(in_data.cb_b);

    data_nxt.even.red   = base_even + r_add;
    data_nxt.even.green = base_even - g_sub;
    data_nxt.even.blue  = base_even + b_add;
    data_nxt.odd.red    = base_odd + r_add;
    data_nxt.odd.green  = base_odd - g_sub;
    data_nxt.odd.blue   = base_odd + b_add;
    data_nxt.frame_end  = in_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

/* rtl/core/y2r_clamp.sv */
// Stage 3: drop fraction bits and saturate to 0..255.
`include "assert_macros.svh"
module y2r_clamp
  import y2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  output logic      in_rdy,
  input  y2r_sum_t  in_data,
  output logic      out_vld,
  input  logic      out_rdy,
  output y2r_pair_t out_data
);

  logic      vld_r;
  y2r_pair_t data_r;
  y2r_pair_t data_nxt;

  // negative -> 0, integer part above 255 -> 255
  function automatic chan_t clamp_chan(input sum_t s);
    chan_t res;
    if (s[19]) begin
      res = '0;
    end else if (|s[18:16]) begin
      res = CHAN_MAX;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  assign in_rdy = !vld_r || out_rdy;

  always_comb begin
    data_nxt.even.red   = clamp_chan(in_data.even.red);
    data_nxt.even.green = clamp_chan(in_data.even.green);
    data_nxt.even.blue  = clamp_chan(in_data.even.blue);
    data_nxt.odd.red    = clamp_chan(in_data.odd.red);
    data_nxt.odd.green  = clamp_chan(in_data.odd.green);
    data_nxt.odd.blue   = clamp_chan(in_data.odd.blue);
    data_nxt.frame_end  = in_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

  `ASSERT_CLK(a_neg_to_zero, clk, rst_n, (in_vld && in_rdy && in_data.even.blue[19]) |=> (out_data.even.blue == 8'h00), "negative blue sum not clamped to zero")
  `ASSERT_CLK(a_high_to_max, clk, rst_n, (in_vld && in_rdy && !in_data.odd.blue[19] && (|in_data.odd.blue[18:16])) |=> (out_data.odd.blue == CHAN_MAX), "blue overflow not saturated")
  `ASSERT_CLK(a_hold_on_stall, clk, rst_n, (vld_r && !out_rdy) |=> (vld_r && $stable(data_r)), "stage 3 lost or changed a held word")

endmodule

/* rtl/core/yuyv_to_rgba_converter.sv */
// Top level: YUYV macropixel to two RGBA pixels, BT.601 integer, 3-stage pipeline.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  in_      | input     | in_valid/in_stall  | luma_even, chroma_blue, luma_odd,
//           |           |                    | chroma_red, frame_end
//  out_     | output    | out_valid/out_stall| red/green/blue/alpha even and odd,
//           |           |                    | frame_end_out
//
// An accepted input word passes through the three registered stages (multiply,
// sum, clamp) to its output word; one word per cycle sustained while out_stall is low.
// Synchronous active-low reset clears the stage valid bits only; no data state.
// out_stall ripples back through the stages: an empty stage keeps accepting,
// so in_stall rises only when all three stages hold words and out_stall is high.
`include "assert_macros.svh"
module yuyv_to_rgba_converter
  import y2r_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,

  input  logic  in_valid,
  output logic  in_stall,
  input  chan_t in_luma_even,
  input  chan_t in_chroma_blue,
  input  chan_t in_luma_odd,
  input  chan_t in_chroma_red,
  input  logic  in_frame_end,

  output logic  out_valid,
  input  logic  out_stall,
  output chan_t out_red_even,
  output chan_t out_green_even,
  output chan_t out_blue_even,
  output chan_t out_alpha_even,
  output chan_t out_red_odd,
  output chan_t out_green_odd,
  output chan_t out_blue_odd,
  output chan_t out_alpha_odd,
  output logic  out_frame_end_out
);

  // stage handshake wires
  logic      mul_rdy;
  logic      mul_vld;
  logic      sum_rdy;
  logic      sum_vld;
  logic      clamp_rdy;
  y2r_prod_t prod_data;
  y2r_sum_t  sum_data;
  y2r_pair_t pair_data;

  // Stage 1: products C*298, E*409, D*100, E*208, D*516
  y2r_mul u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_valid),
    .in_rdy      (mul_rdy),
    .luma_even   (in_luma_even),
    .chroma_blue (in_chroma_blue),
    .luma_odd    (in_luma_odd),
    .chroma_red  (in_chroma_red),
    .frame_end   (in_frame_end),
    .out_vld     (mul_vld),
    .out_rdy     (sum_rdy),
    .out_data    (prod_data)
  );

  // Stage 2: R, G, B sums for both pixels, +128 rounding
  y2r_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (mul_vld),
    .in_rdy   (sum_rdy),
    .in_data  (prod_data),
    .out_vld  (sum_vld),
    .out_rdy  (clamp_rdy),
    .out_data (sum_data)
  );

  // Stage 3: >>8 and saturate; its register is the output register
  y2r_clamp u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sum_vld),
    .in_rdy   (clamp_rdy),
    .in_data  (sum_data),
    .out_vld  (out_valid),
    .out_rdy  (!out_stall),
    .out_data (pair_data)
  );

  assign in_stall = !mul_rdy;

  assign out_red_even      = pair_data.even.red;
  assign out_green_even    = pair_data.even.green;
  assign out_blue_even     = pair_data.even.blue;
  assign out_alpha_even    = CHAN_MAX;
  assign out_red_odd       = pair_data.odd.red;
  assign out_green_odd     = pair_data.odd.green;
  assign out_blue_odd      = pair_data.odd.blue;
  assign out_alpha_odd     = CHAN_MAX;
  assign out_frame_end_out = pair_data.frame_end;

  // input backpressure only when the whole pipe is full and blocked
  `ASSERT_CLK(a_stall_only_full, clk, rst_n, in_stall |-> (out_valid && out_stall && sum_vld && mul_vld), "input stalled while pipeline had room")
  // free-flowing pipe (out_stall low) delivers an accepted word to the output
  `ASSERT_CLK(a_latency, clk, rst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid, "accepted word did not reach output")
  // frame marker travels with its word
  `ASSERT_CLK(a_frame_end, clk, rst_n, (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> (out_frame_end_out == $past(in_frame_end, 3)), "frame-end marker misaligned")

endmodule
